>>> hw/rtl/fvl_pkg.sv
// Shared types and constants for the fiducial velocity and Lorentz factor pipeline.
`timescale 1ns / 1ps
package fvl_pkg;

  // velocity_mode codes
  localparam logic [1:0] MODE_COPY  = 2'd0;
  localparam logic [1:0] MODE_MIXED = 2'd1;
  localparam logic [1:0] MODE_ZERO  = 2'd2;

  // configuration register indexes
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_FLOOR = 1'b1;

  localparam logic [1:0]  MODE_RESET  = MODE_ZERO;
  localparam logic [31:0] FLOOR_RESET = 32'd0;

  localparam logic [31:0] W_ONE = 32'h0100_0000;   // 1.0 in Q8.24
  localparam logic [31:0] W_MAX = 32'hFFFF_FFFF;

  // pipeline depths
  localparam int DAMP_BITS  = 32;   // damping quotient bits
  localparam int RECIP_BITS = 64;   // bits of 2^78 / d
  localparam int ROOT_BITS  = 32;   // bits of the square root

  // three velocity components, each Q2.30 two's complement
  typedef logic [2:0][31:0] vec_t;

  // six metric components: xx, xy, xz, yy, yz, zz
  typedef logic [5:0][31:0] metric_t;

  // fluid values that copy mode passes straight through
  typedef struct packed {
    vec_t        v;
    logic [31:0] lorentz;
  } pass_t;

  // data that rides alongside the arithmetic after damping
  typedef struct packed {
    vec_t  v;      // damped velocity
    pass_t p;
  } side_t;

endpackage

>>> hw/rtl/fvl_damp.sv
// Density damping: magnitude product and a restoring divider, one quotient bit a stage.
`timescale 1ns / 1ps
module fvl_damp import fvl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  vec_t        v_in,
  input  logic [31:0] dens,
  input  logic [31:0] floor_val,
  input  metric_t     g_in,
  input  pass_t       p_in,
  output logic        out_valid,
  output vec_t        v_out,
  output metric_t     g_out,
  output pass_t       p_out
);

  typedef struct packed {
    logic       damp;
    logic [2:0] neg;
    vec_t       v;
    metric_t    g;
    pass_t      p;
  } dside_t;

  // {remainder, numerator low bits / quotient} per lane
  logic [2:0][63:0] acc [0:DAMP_BITS];
  logic             vld [0:DAMP_BITS];
  dside_t           sd  [0:DAMP_BITS];

  function automatic logic [63:0] div_step(input logic [63:0] a, input logic [31:0] dv);
    logic [32:0] t;
    logic [32:0] rn;
    logic        ge;
    t  = a[63:31];
    ge = t >= {1'b0, dv};
    rn = ge ? t - {1'b0, dv} : t;
    return {rn[31:0], a[30:0], ge};
  endfunction

  // first stage: magnitudes and the full product |v| * density
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        acc[0][i]   <= {32'd0, (v_in[i][31] ? 32'd0 - v_in[i] : v_in[i])} * {32'd0, dens};
        sd[0].neg[i] <= v_in[i][31];
      end
      sd[0].damp <= dens < floor_val;
      sd[0].v    <= v_in;
      sd[0].g    <= g_in;
      sd[0].p    <= p_in;
    end
  end

  // divider stages
  for (genvar k = 0; k < DAMP_BITS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          acc[k+1][i] <= div_step(acc[k][i], floor_val);
        end
        sd[k+1] <= sd[k];
      end
    end
  end

  // restore the sign on damped lanes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sd[DAMP_BITS].damp) begin
        v_out[i] = sd[DAMP_BITS].neg[i] ? 32'd0 - acc[DAMP_BITS][i][31:0]
                                        : acc[DAMP_BITS][i][31:0];
      end else begin
        v_out[i] = sd[DAMP_BITS].v[i];
      end
    end
  end

  assign out_valid = vld[DAMP_BITS];
  assign g_out     = sd[DAMP_BITS].g;
  assign p_out     = sd[DAMP_BITS].p;

endmodule

>>> hw/rtl/fvl_norm.sv
// Lowering with the metric and the squared norm, ending in d = 1 - v2.
`timescale 1ns / 1ps
module fvl_norm import fvl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  metric_t     g_in,
  input  side_t       s_in,
  output logic        out_valid,
  output logic [39:0] d_out,
  output logic        sl_out,
  output side_t       s_out
);

  logic [2:0][2:0][31:0] gm;
  logic [2:0][31:0]      vm;

  logic                  vld1, vld2, vld3, vld4;
  side_t                 s1, s2, s3, s4;
  logic [2:0][2:0][63:0] prod1;
  logic [2:0][2:0]       sgn1;
  logic [2:0][37:0]      lsum2;
  logic [2:0][63:0]      lo3;
  logic [2:0][35:0]      hi3;
  logic [2:0]            sgn3;
  logic [39:0]           d4;
  logic                  sl4;

  logic [2:0][37:0]      lsum_next;
  logic [2:0][37:0]      lmag;
  logic [40:0]           v2;
  logic [41:0]           d_full;

  // full symmetric metric and velocity magnitudes
  always_comb begin
    gm[0][0] = g_in[0]; gm[0][1] = g_in[1]; gm[0][2] = g_in[2];
    gm[1][0] = g_in[1]; gm[1][1] = g_in[3]; gm[1][2] = g_in[4];
    gm[2][0] = g_in[2]; gm[2][1] = g_in[4]; gm[2][2] = g_in[5];
    for (int j = 0; j < 3; j++) begin
      vm[j] = s_in.v[j][31] ? 32'd0 - s_in.v[j] : s_in.v[j];
    end
  end

  // row sums of truncated g_ij v_j
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lsum_next[i] = '0;
      for (int j = 0; j < 3; j++) begin
        lsum_next[i] = lsum_next[i] + (sgn1[i][j] ? 38'd0 - {2'b00, prod1[i][j][63:28]}
                                                   : {2'b00, prod1[i][j][63:28]});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lmag[i] = lsum2[i][37] ? 38'd0 - lsum2[i] : lsum2[i];
    end
  end

  // v2 from the split products, then d
  always_comb begin
    logic [39:0] m;
    v2 = '0;
    for (int i = 0; i < 3; i++) begin
      m  = {hi3[i], 2'b00} + {6'd0, lo3[i][63:30]};
      v2 = v2 + (sgn3[i] ? 41'd0 - {1'b0, m} : {1'b0, m});
    end
    d_full = (42'd1 << 30) - {v2[40], v2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod1[i][j] <= {32'd0, (gm[i][j][31] ? 32'd0 - gm[i][j] : gm[i][j])} * {32'd0, vm[j]};
          sgn1[i][j]  <= gm[i][j][31] ^ s_in.v[j][31];
        end
      end
      s1    <= s_in;
      lsum2 <= lsum_next;
      s2    <= s1;
      for (int i = 0; i < 3; i++) begin
        lo3[i]  <= {32'd0, lmag[i][31:0]} *
                   {32'd0, (s2.v[i][31] ? 32'd0 - s2.v[i] : s2.v[i])};
        hi3[i]  <= {32'd0, lmag[i][35:32]} *
                   {4'd0, (s2.v[i][31] ? 32'd0 - s2.v[i] : s2.v[i])};
        sgn3[i] <= lsum2[i][37] ^ s2.v[i][31];
      end
      s3  <= s2;
      d4  <= d_full[39:0];
      sl4 <= d_full[41] | (d_full[40:0] <= 41'd16384);
      s4  <= s3;
    end
  end

  assign out_valid = vld4;
  assign d_out     = d4;
  assign sl_out    = sl4;
  assign s_out     = s4;

endmodule

>>> hw/rtl/fvl_rsqrt.sv
// W = floor(sqrt(floor(2^78 / d))): pipelined restoring divider then digit-by-digit root.
`timescale 1ns / 1ps
module fvl_rsqrt import fvl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [39:0] d_in,
  input  logic        sl_in,
  input  side_t       s_in,
  output logic        out_valid,
  output logic [31:0] w_out,
  output logic        sl_out,
  output side_t       s_out
);

  typedef struct packed {
    logic  sl;
    side_t s;
  } rside_t;

  // divider pipe
  logic [39:0] rem  [0:RECIP_BITS];
  logic [63:0] quo  [0:RECIP_BITS];
  logic [39:0] dv   [0:RECIP_BITS];
  logic        dvld [0:RECIP_BITS];
  rside_t      dsd  [0:RECIP_BITS];

  // root pipe
  logic [33:0] rr   [0:ROOT_BITS];
  logic [31:0] root [0:ROOT_BITS];
  logic [63:0] rad  [0:ROOT_BITS];
  logic        rvld [0:ROOT_BITS];
  rside_t      rsd  [0:ROOT_BITS];

  // leading numerator bits leave 2^14, which is below any valid d
  assign rem[0]  = 40'd16384;
  assign quo[0]  = '0;
  assign dv[0]   = d_in;
  assign dvld[0] = in_valid;
  assign dsd[0]  = '{sl: sl_in, s: s_in};

  for (genvar k = 0; k < RECIP_BITS; k++) begin : g_div
    logic [40:0] t;
    logic        ge;
    logic [40:0] rn;

    always_comb begin
      t  = {rem[k], 1'b0};
      ge = t >= {1'b0, dv[k]};
      rn = ge ? t - {1'b0, dv[k]} : t;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[k+1] <= 1'b0;
      end else if (en) begin
        dvld[k+1] <= dvld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= rn[39:0];
        quo[k+1] <= {quo[k][62:0], ge};
        dv[k+1]  <= dv[k];
        dsd[k+1] <= dsd[k];
      end
    end
  end

  assign rr[0]   = '0;
  assign root[0] = '0;
  assign rad[0]  = quo[RECIP_BITS];
  assign rvld[0] = dvld[RECIP_BITS];
  assign rsd[0]  = dsd[RECIP_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
    logic [35:0] t;
    logic [35:0] trial;
    logic        ge;
    logic [35:0] rn;

    always_comb begin
      t     = {rr[k], rad[k][63:62]};
      trial = {2'b00, root[k], 2'b01};
      ge    = t >= trial;
      rn    = ge ? t - trial : t;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rvld[k+1] <= 1'b0;
      end else if (en) begin
        rvld[k+1] <= rvld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[k+1]   <= rn[33:0];
        root[k+1] <= {root[k][30:0], ge};
        rad[k+1]  <= {rad[k][61:0], 2'b00};
        rsd[k+1]  <= rsd[k];
      end
    end
  end

  assign out_valid = rvld[ROOT_BITS];
  assign w_out     = rsd[ROOT_BITS].sl ? W_MAX : root[ROOT_BITS];
  assign sl_out    = rsd[ROOT_BITS].sl;
  assign s_out     = rsd[ROOT_BITS].s;

endmodule

>>> hw/rtl/fiducial_velocity_lorentz.sv
// Top level: configuration registers, the arithmetic pipe and a two-word output buffer.
//
//  channel   signals                                         direction
//  input     in_valid, in_ready, fluid_*, density, metric_*  in  (word per grid point)
//  output    out_valid, out_ready, out_*, superluminal       out (word per grid point)
//  config    cfg_write, cfg_index, cfg_data                  in  (no handshake)
//
//  One word is taken every cycle unless the full buffer stalls the pipe; the stages
//  are 1 product, 32 damping divider, 4 norm, 64 reciprocal divider, 32 root, 1 buffer.
//  The pipe advances as a whole while the output buffer has room; two buffered
//  words let input continue while a result waits.
//  Reset is synchronous: it clears valid bits, buffer count and the registers.
`timescale 1ns / 1ps
module fiducial_velocity_lorentz import fvl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] fluid_vx,
  input  logic [31:0] fluid_vy,
  input  logic [31:0] fluid_vz,
  input  logic [31:0] fluid_lorentz,
  input  logic [31:0] density,
  input  logic [31:0] metric_xx,
  input  logic [31:0] metric_xy,
  input  logic [31:0] metric_xz,
  input  logic [31:0] metric_yy,
  input  logic [31:0] metric_yz,
  input  logic [31:0] metric_zz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_vx,
  output logic [31:0] out_vy,
  output logic [31:0] out_vz,
  output logic [31:0] out_lorentz,
  output logic        superluminal
);

  typedef struct packed {
    vec_t        v;
    logic [31:0] w;
    logic        sl;
  } res_t;

  logic [1:0]  velocity_mode;
  logic [31:0] density_floor;
  logic        en;

  vec_t    v_in;
  metric_t g_in;
  pass_t   p_in;

  logic    dmp_valid;
  vec_t    dmp_v;
  metric_t dmp_g;
  pass_t   dmp_p;

  logic        nrm_valid;
  logic [39:0] nrm_d;
  logic        nrm_sl;
  side_t       nrm_s;

  logic        rs_valid;
  logic [31:0] rs_w;
  logic        rs_sl;
  side_t       rs_s;

  res_t       res;
  res_t       buf_word [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] cnt;
  logic       push, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_mode <= MODE_RESET;
      density_floor <= FLOOR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:  velocity_mode <= cfg_data[1:0];
        REG_FLOOR: density_floor <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign v_in = {fluid_vz, fluid_vy, fluid_vx};
  assign g_in = {metric_zz, metric_yz, metric_yy, metric_xz, metric_xy, metric_xx};
  assign p_in = '{v: v_in, lorentz: fluid_lorentz};

  // pipe moves while the buffer can take the last stage's word
  assign en       = (cnt != 2'd2) || out_ready;
  assign in_ready = en;

  fvl_damp u_damp (
    .clk, .rst, .en,
    .in_valid  (in_valid),
    .v_in      (v_in),
    .dens      (density),
    .floor_val (density_floor),
    .g_in      (g_in),
    .p_in      (p_in),
    .out_valid (dmp_valid),
    .v_out     (dmp_v),
    .g_out     (dmp_g),
    .p_out     (dmp_p)
  );

  fvl_norm u_norm (
    .clk, .rst, .en,
    .in_valid  (dmp_valid),
    .g_in      (dmp_g),
    .s_in      ('{v: dmp_v, p: dmp_p}),
    .out_valid (nrm_valid),
    .d_out     (nrm_d),
    .sl_out    (nrm_sl),
    .s_out     (nrm_s)
  );

  fvl_rsqrt u_rsqrt (
    .clk, .rst, .en,
    .in_valid  (nrm_valid),
    .d_in      (nrm_d),
    .sl_in     (nrm_sl),
    .s_in      (nrm_s),
    .out_valid (rs_valid),
    .w_out     (rs_w),
    .sl_out    (rs_sl),
    .s_out     (rs_s)
  );

  // mode select on the finished word
  always_comb begin
    case (velocity_mode)
      MODE_COPY:  res = '{v: rs_s.p.v, w: rs_s.p.lorentz, sl: 1'b0};
      MODE_MIXED: res = '{v: rs_s.v, w: rs_w, sl: rs_sl};
      default:    res = '{v: '0, w: W_ONE, sl: 1'b0};
    endcase
  end

  // two-word output buffer
  assign push = en && rs_valid;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_word[wr_ptr] <= res;
    end
  end

  assign out_valid    = cnt != 2'd0;
  assign out_vx       = buf_word[rd_ptr].v[0];
  assign out_vy       = buf_word[rd_ptr].v[1];
  assign out_vz       = buf_word[rd_ptr].v[2];
  assign out_lorentz  = buf_word[rd_ptr].w;
  assign superluminal = buf_word[rd_ptr].sl;

  // buffer never overfills
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");

  // a push into a full buffer needs a pop in the same cycle
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (push && cnt == 2'd2) |-> out_ready)
    else $error("push into full output buffer");

  // the superluminal flag always comes with a saturated Lorentz factor
  a_sat_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && superluminal) |-> (out_lorentz == W_MAX))
    else $error("superluminal word without saturated Lorentz factor");

endmodule
